### hw/rtl/mrsp_pkg.sv
// Types and constants shared by the MIDI running-status parser.
// No dependencies.
package mrsp_pkg;

  // Parse position codes
  localparam logic [1:0] POS_IDLE   = 2'd0;
  localparam logic [1:0] POS_STATUS = 2'd1;
  localparam logic [1:0] POS_FIRST  = 2'd2;
  localparam logic [1:0] POS_DONE   = 2'd3;

  localparam logic [7:0] STATUS_FLAG = 8'h80;
  localparam logic [7:0] SYSTEM_HI   = 8'hF0;
  localparam logic [7:0] MASK_HI3    = 8'hE0;
  localparam logic [7:0] PROG_CHANGE = 8'hC0;
  localparam logic [7:0] CHAN_PRESS  = 8'hD0;

  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_LONG  = 2'd3;

  typedef struct packed {
    logic [1:0] pos;
    logic [7:0] status;
    logic [6:0] first;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [1:0] message_length;
  } parse_result_t;

  function automatic logic is_short_msg(input logic [7:0] st);
    return ((st & MASK_HI3) == PROG_CHANGE) || ((st & SYSTEM_HI) == CHAN_PRESS);
  endfunction

endpackage

### hw/rtl/mrsp_decode.sv
// Next-state and result logic for one MIDI byte.
// Depends on mrsp_pkg.
module mrsp_decode import mrsp_pkg::*; (
  input  parse_state_t  state,
  input  logic [7:0]    midi_byte,
  output parse_state_t  state_next,
  output parse_result_t result
);

  logic       is_status;
  logic       is_system;
  logic [6:0] d;

  assign is_status = midi_byte[7];
  assign is_system = (midi_byte & SYSTEM_HI) == SYSTEM_HI;
  assign d         = midi_byte[6:0];

  always_comb begin
    state_next            = state;
    result.emit           = 1'b0;
    result.status_byte    = state.status;
    result.first_data     = d;
    result.second_data    = 7'd0;
    result.message_length = LEN_SHORT;

    if (is_status) begin
      // any status byte restarts parsing; system bytes drop to idle
      if (is_system) begin
        state_next.pos = POS_IDLE;
      end else begin
        state_next.pos    = POS_STATUS;
        state_next.status = midi_byte;
      end
    end else begin
      unique case (state.pos)
        POS_IDLE: begin
          state_next.pos = POS_IDLE;
        end
        POS_STATUS, POS_DONE: begin
          state_next.first = d;
          if (is_short_msg(state.status)) begin
            result.emit    = 1'b1;
            state_next.pos = POS_DONE;
          end else begin
            state_next.pos = POS_FIRST;
          end
        end
        POS_FIRST: begin
          result.emit           = 1'b1;
          result.first_data     = state.first;
          result.second_data    = d;
          result.message_length = LEN_LONG;
          state_next.pos        = POS_DONE;
        end
        default: begin
          state_next.pos = POS_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/midi_running_status_parser_core.sv
// MIDI running-status parser: input register, decode, result register.
// An accepted byte is held in the input register, then decoded into the result register.
// Throughput: one byte per cycle while the result register can take a beat, with a combinational decode stage.
// Reset (rst, synchronous, active high): parser idle, held status and data
// cleared, both pipeline registers empty.
// Depends on mrsp_pkg and mrsp_decode.
module midi_running_status_parser_core import mrsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] midi_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] status_byte,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  output logic [1:0] message_length
);

  // input register stage
  logic       byte_valid;
  logic [7:0] byte_q;

  // parser state
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t result;

  // the held byte moves on when the result register can take a beat
  logic advance;

  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  mrsp_decode u_decode (
    .state      (state),
    .midi_byte  (byte_q),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= midi_byte;
    end
  end

  // parse state only changes when a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{pos: POS_IDLE, status: 8'd0, first: 7'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register: loads on a completed message, drains when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      status_byte    <= result.status_byte;
      first_data     <= result.first_data;
      second_data    <= result.second_data;
      message_length <= result.message_length;
    end
  end

endmodule

### test/tb_midi_running_status_parser_core.sv
// Self-checking testbench for midi_running_status_parser_core.
// Holds a message tracker class that predicts completed MIDI messages and checks result beats.
// Depends on mrsp_pkg and the parser RTL.
module tb_midi_running_status_parser_core import mrsp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RST_CYCLES  = 11;
  localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int TAIL_CYCLES = 10;    // settle time after the last result
  localparam int NUM_ITEMS   = 1300;
  localparam int IDLE_PCT    = 36;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [1:0] len;
  } midi_msg_t;

  // Predicts completed channel messages from accepted bytes and checks each
  // result beat against the oldest prediction.
  class midi_msg_tracker;
    logic [1:0] pos;
    logic [7:0] held_status;
    logic [6:0] held_first;
    midi_msg_t  pending_msgs[$];
    int         err_count;

    function new();
      pos         = POS_IDLE;
      held_status = '0;
      held_first  = '0;
      err_count   = 0;
    endfunction

    // Any status byte restarts; system bytes drop back to idle.
    function void restart(input logic [7:0] b);
      if ((b & SYSTEM_HI) != SYSTEM_HI) begin
        held_status = b;
        pos         = POS_STATUS;
      end else begin
        pos = POS_IDLE;
      end
    endfunction

    function void note_byte(input logic [7:0] b);
      midi_msg_t m;
      logic      two_byte;
      two_byte = ((held_status & MASK_HI3) == PROG_CHANGE) ||
                 ((held_status & SYSTEM_HI) == CHAN_PRESS);
      if ((b & STATUS_FLAG) != 0) begin
        restart(b);
      end else if (pos == POS_STATUS || pos == POS_DONE) begin
        held_first = b[6:0];
        if (two_byte) begin
          m = '{status: held_status, d1: b[6:0], d2: 7'd0, len: LEN_SHORT};
          pending_msgs.push_back(m);
          pos = POS_DONE;
        end else begin
          pos = POS_FIRST;
        end
      end else if (pos == POS_FIRST) begin
        m = '{status: held_status, d1: held_first, d2: b[6:0], len: LEN_LONG};
        pending_msgs.push_back(m);
        pos = POS_DONE;
      end
      // data byte in idle: ignored
    endfunction

    function void check_msg(input logic [7:0] st, input logic [6:0] d1,
                            input logic [6:0] d2, input logic [1:0] len);
      midi_msg_t m;
      if (pending_msgs.size() == 0) begin
        $error("unexpected result beat: status_byte %h first_data %h second_data %h len %0d",
               st, d1, d2, len);
        err_count++;
        return;
      end
      m = pending_msgs.pop_front();
      if (st !== m.status) begin
        $error("status_byte: expected %h, got %h", m.status, st);
        err_count++;
      end
      if (d1 !== m.d1) begin
        $error("first_data: expected %h, got %h", m.d1, d1);
        err_count++;
      end
      if (d2 !== m.d2) begin
        $error("second_data: expected %h, got %h", m.d2, d2);
        err_count++;
      end
      if (len !== m.len) begin
        $error("message_length: expected %0d, got %0d", m.len, len);
        err_count++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] midi_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] status_byte;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [1:0] message_length;

  midi_msg_tracker trk = new();

  bit idle_on    = 1'b1;  // random idling on both sides
  bit hold_done  = 1'b0;  // long hold-off already run
  bit drain_done = 1'b0;  // mid-run drain already run
  int hold_left  = 0;     // receiver hold-off cycles still to run
  int item_cnt   = 0;
  int stall_cnt  = 0;

  midi_running_status_parser_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .midi_byte     (midi_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status_byte   (status_byte),
    .first_data    (first_data),
    .second_data   (second_data),
    .message_length(message_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats are sampled at the edge; all driving is by NBA, so the values seen
  // here are the ones the DUT registers.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) trk.note_byte(midi_byte);
    if (!rst && out_valid && out_ready)
      trk.check_msg(status_byte, first_data, second_data, message_length);
  end

  // Watchdog: counts cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Result side: random back-pressure, and one long hold-off once the run
  // is well under way.
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && item_cnt >= 300) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Holds valid high with a fixed payload until the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    in_valid  <= 1'b1;
    midi_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Random idle gap, then one beat.
  task automatic send_item(input logic [7:0] b);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid  <= 1'b0;
      midi_byte <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    send_byte(b);
    item_cnt++;
  endtask

  // Sender stops until every predicted message has come out. It first waits on the
  // clock so the last accepted byte has been noted by the tracker.
  task automatic drain_msgs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trk.pending_msgs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_status();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'hEF;
    return 8'(8'h80 + $urandom_range(0, 8'h6F));
  endfunction

  // One status byte followed by several messages under running status, with
  // the odd real-time byte, stray status or truncation thrown in.
  task automatic send_burst();
    logic [7:0] st;
    int         n_msgs;
    int         n_data;
    st     = pick_status();
    n_msgs = $urandom_range(1, 6);
    n_data = (((st & MASK_HI3) == PROG_CHANGE) || ((st & SYSTEM_HI) == CHAN_PRESS)) ? 1 : 2;
    send_item(st);
    for (int m = 0; m < n_msgs; m++) begin
      for (int k = 0; k < n_data; k++) begin
        case ($urandom_range(0, 49))
          0: begin
            send_item(8'(8'hF8 + $urandom_range(0, 7)));  // real-time abort
            return;
          end
          1: begin
            send_item(pick_status());                     // restart mid-message
            return;
          end
          2: return;                                      // truncated
          default: send_item(8'($urandom_range(0, 127)));
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle drops, both lengths, running status, both kinds of abort.
    directed = '{8'h00, 8'h7F, 8'hF0, 8'hFF,      // ignored in idle
                 8'h90, 8'h00, 8'h7F,             // note on, data extremes
                 8'h55, 8'h2A,                    // running status
                 8'hC0, 8'h00, 8'h7F,             // program change, reused
                 8'hDF, 8'h40,                    // channel pressure
                 8'h80, 8'h12, 8'hF8, 8'h34,      // real-time aborts, data dropped
                 8'hEF, 8'h01, 8'hB3, 8'h05, 8'h06, // status restart mid-message
                 8'hFE, 8'h33};                   // system after completion
    foreach (directed[i]) send_item(directed[i]);
    drain_msgs();

    item_cnt = 0;
    while (item_cnt < NUM_ITEMS) begin
      if (!drain_done && item_cnt >= 700) begin
        drain_msgs();
        drain_done = 1'b1;
      end
      idle_on = !(item_cnt >= 900 && item_cnt < 1100);
      if ($urandom_range(0, 99) < 85) send_burst();
      else send_item(8'($urandom_range(0, 255)));
    end
    idle_on = 1'b1;

    drain_msgs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trk.err_count == 0 && trk.pending_msgs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (trk.pending_msgs.size() != 0)
        $error("%0d expected messages never arrived", trk.pending_msgs.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
